FILE: sv/bfl_pkg.sv
// Shared constants, types and the helper function of the reachability query block.
package bfl_pkg;

  localparam int VERTEX_COUNT = 1024;
  localparam int LABEL_WORDS  = 8;

  localparam int VA_W   = $clog2(VERTEX_COUNT);
  localparam int WSEL_W = (LABEL_WORDS > 1) ? $clog2(LABEL_WORDS) : 1;
  localparam int WORD_W = 32;
  localparam int MARK_W = 11;
  // Sum of 27 weights, each below LABEL_WORDS (at most 7).
  localparam int SUM_W  = 11;

  typedef enum logic [1:0] {
    FUNC_REC   = 2'd0,
    FUNC_OUT   = 2'd1,
    FUNC_IN    = 2'd2,
    FUNC_QUERY = 2'd3
  } func_t;

  typedef struct packed {
    logic [MARK_W-1:0] start_mark;
    logic [MARK_W-1:0] end_mark;
    logic              root;
    logic              leaf;
  } rec_t;

  typedef logic [LABEL_WORDS-1:0][WORD_W-1:0] label_row_t;

  typedef struct packed {
    logic              valid;
    logic              same;
    logic              below;
    logic              in_range;
    logic              end_lt;
    logic              start_le;
    logic              leaf;
    logic              root;
    logic              out_ok;
    logic              in_ok;
    logic [WSEL_W-1:0] leaf_sel;
    logic [4:0]        leaf_bit;
    logic [WSEL_W-1:0] root_sel;
    logic [4:0]        root_bit;
  } eval_t;

  // Word number of a bit index: (x) mod LABEL_WORDS, where x = index >> 5.
  // Non power-of-two counts: sum of per-bit weights (2^i mod LABEL_WORDS),
  // then five conditional subtracts (sum stays below 27 * LABEL_WORDS).
  function automatic logic [WSEL_W-1:0] word_mod(input logic [26:0] x);
    logic [SUM_W-1:0] s;
    int               w;
    s = '0;
    w = 1;
    if ((LABEL_WORDS & (LABEL_WORDS - 1)) == 0) begin
      s = SUM_W'(x & 27'(LABEL_WORDS - 1));
    end else begin
      for (int i = 0; i < 27; i++) begin
        if (x[i]) s = s + SUM_W'(w);
        w = w * 2;
        if (w >= LABEL_WORDS) w = w - LABEL_WORDS;
      end
      for (int k = 4; k >= 0; k--) begin
        if (s >= SUM_W'(LABEL_WORDS << k)) s = s - SUM_W'(LABEL_WORDS << k);
      end
    end
    return WSEL_W'(s);
  endfunction

endpackage

FILE: sv/bfl_if.sv
// Valid/ready channel interfaces for request items and query results.
interface bfl_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [9:0]  vertex;
  logic [9:0]  target_vertex;
  logic [2:0]  word_index;
  logic [31:0] word_value;
  logic [10:0] interval_start;
  logic [10:0] interval_end;
  logic        no_in_edges;
  logic        no_out_edges;

  modport source (
    output valid, func, vertex, target_vertex, word_index, word_value,
           interval_start, interval_end, no_in_edges, no_out_edges,
    input  ready
  );
  modport sink (
    input  valid, func, vertex, target_vertex, word_index, word_value,
           interval_start, interval_end, no_in_edges, no_out_edges,
    output ready
  );
endinterface

interface bfl_result_if;
  logic valid;
  logic ready;
  logic reachable;

  modport source (output valid, reachable, input ready);
  modport sink (input valid, reachable, output ready);
endinterface

FILE: sv/bfl_ram.sv
// Generic RAM: one write port, two registered read ports.
module bfl_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

FILE: sv/bfl_eval.sv
// Compare stage: order and interval tests, word-wise subset tests, bit-index decode.
module bfl_eval import bfl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       s1_valid,
  input  logic [9:0] src,
  input  logic [9:0] dst,
  input  rec_t       rec_src,
  input  rec_t       rec_dst,
  input  label_row_t so,
  input  label_row_t to,
  input  label_row_t si,
  input  label_row_t ti,
  output eval_t      s2,
  output label_row_t s2_so,
  output label_row_t s2_ti
);

  eval_t s2_next;
  logic  out_ok;
  logic  in_ok;

  always_comb begin
    out_ok = 1'b1;
    in_ok  = 1'b1;
    for (int w = 0; w < LABEL_WORDS; w++) begin
      if ((so[w] & to[w]) != to[w]) out_ok = 1'b0;
      if ((si[w] & ti[w]) != si[w]) in_ok  = 1'b0;
    end
  end

  always_comb begin
    s2_next.valid    = s1_valid;
    s2_next.same     = (src == dst);
    s2_next.below    = (src < dst);
    s2_next.in_range = (32'(src) < VERTEX_COUNT) && (32'(dst) < VERTEX_COUNT);
    s2_next.end_lt   = (rec_src.end_mark < rec_dst.end_mark);
    s2_next.start_le = (rec_src.start_mark <= rec_dst.start_mark);
    s2_next.leaf     = rec_dst.leaf;
    s2_next.root     = rec_src.root;
    s2_next.out_ok   = out_ok;
    s2_next.in_ok    = in_ok;
    s2_next.leaf_sel = word_mod(to[0][31:5]);
    s2_next.leaf_bit = to[0][4:0];
    s2_next.root_sel = word_mod(si[0][31:5]);
    s2_next.root_bit = si[0][4:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2 <= '0;
    end else if (en) begin
      s2 <= s2_next;
    end
  end

  // word payload for the bit-index tests
  always_ff @(posedge clk) begin
    if (en) begin
      s2_so <= so;
      s2_ti <= ti;
    end
  end

endmodule

FILE: sv/bfl_label_reachability_test.sv
// Top level: vertex table memories and three-stage reachability query pipeline.
//
//  channel  dir  payload                                          transaction
//  -------  ---  -----------------------------------------------  -------------------------
//  item     in   func vertex target_vertex word_index word_value  valid & ready at clk edge
//                interval_start interval_end no_in_edges ...
//  result   out  reachable                                        valid & ready at clk edge
//
// One item enters per cycle while the output register is not held. A query's result
// passes the memory read registers (loaded at its transaction edge), the compare stage and
// the decision/output stage, whose output register it can then be taken from.
// Writes update the tables at their own transaction edge and give no result.
// rst clears the pipeline valid bits and the compare-stage register; the tables hold garbage until written.
// A stalled result freezes the whole pipeline, memory read registers included;
// nothing is dropped or replayed.
module bfl_label_reachability_test import bfl_pkg::*; (
  input logic          clk,
  input logic          rst,
  bfl_item_if.sink     item,
  bfl_result_if.source result
);

  // global advance: everything moves unless the output register is held
  logic adv;
  logic accept;
  logic vtx_ok;
  logic word_ok;

  assign adv        = !result.valid || result.ready;
  assign item.ready = adv;
  assign accept     = item.valid && adv;
  assign vtx_ok     = (32'(item.vertex) < VERTEX_COUNT);
  assign word_ok    = (32'(item.word_index) < LABEL_WORDS);

  logic [VA_W-1:0] waddr;
  logic [VA_W-1:0] raddr_src;
  logic [VA_W-1:0] raddr_dst;

  assign waddr     = VA_W'(item.vertex);
  assign raddr_src = VA_W'(item.vertex);
  assign raddr_dst = VA_W'(item.target_vertex);

  // ---------------- stage 1: vertex records and label words --------------
  rec_t rec_wdata;
  rec_t rec_src;
  rec_t rec_dst;
  logic rec_we;

  assign rec_we = accept && (item.func == FUNC_REC) && vtx_ok;

  always_comb begin
    rec_wdata.start_mark = item.interval_start;
    rec_wdata.end_mark   = item.interval_end;
    rec_wdata.root       = item.no_in_edges;
    rec_wdata.leaf       = item.no_out_edges;
  end

  bfl_ram #(
    .DEPTH (VERTEX_COUNT),
    .WIDTH ($bits(rec_t)),
    .AW    (VA_W)
  ) u_rec_ram (
    .clk     (clk),
    .we      (rec_we),
    .waddr   (waddr),
    .wdata   (rec_wdata),
    .re      (adv),
    .raddr_a (raddr_src),
    .raddr_b (raddr_dst),
    .rdata_a (rec_src),
    .rdata_b (rec_dst)
  );

  // one RAM per label word and direction, so a query sees the whole row of both vertices
  label_row_t so;
  label_row_t to;
  label_row_t si;
  label_row_t ti;

  for (genvar w = 0; w < LABEL_WORDS; w++) begin : g_word
    logic out_we;
    logic in_we;

    assign out_we = accept && (item.func == FUNC_OUT) && vtx_ok && word_ok &&
                    (32'(item.word_index) == w);
    assign in_we  = accept && (item.func == FUNC_IN) && vtx_ok && word_ok &&
                    (32'(item.word_index) == w);

    bfl_ram #(
      .DEPTH (VERTEX_COUNT),
      .WIDTH (WORD_W),
      .AW    (VA_W)
    ) u_out_ram (
      .clk     (clk),
      .we      (out_we),
      .waddr   (waddr),
      .wdata   (item.word_value),
      .re      (adv),
      .raddr_a (raddr_src),
      .raddr_b (raddr_dst),
      .rdata_a (so[w]),
      .rdata_b (to[w])
    );

    bfl_ram #(
      .DEPTH (VERTEX_COUNT),
      .WIDTH (WORD_W),
      .AW    (VA_W)
    ) u_in_ram (
      .clk     (clk),
      .we      (in_we),
      .waddr   (waddr),
      .wdata   (item.word_value),
      .re      (adv),
      .raddr_a (raddr_src),
      .raddr_b (raddr_dst),
      .rdata_a (si[w]),
      .rdata_b (ti[w])
    );
  end

  // query tag travels alongside the read data
  logic       s1_valid;
  logic [9:0] s1_src;
  logic [9:0] s1_dst;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= item.valid && (item.func == FUNC_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_src <= item.vertex;
      s1_dst <= item.target_vertex;
    end
  end

  // ---------------- stage 2: compares --------------------------------------
  eval_t      s2;
  label_row_t s2_so;
  label_row_t s2_ti;

  bfl_eval u_eval (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .s1_valid (s1_valid),
    .src      (s1_src),
    .dst      (s1_dst),
    .rec_src  (rec_src),
    .rec_dst  (rec_dst),
    .so       (so),
    .to       (to),
    .si       (si),
    .ti       (ti),
    .s2       (s2),
    .s2_so    (s2_so),
    .s2_ti    (s2_ti)
  );

  // ---------------- stage 3: decision and output register ------------------
  logic out_pass;
  logic in_pass;
  logic reach_next;

  // leaf target: single bit of the source's out-label; root source: single
  // bit of the target's in-label
  assign out_pass = s2.leaf ? s2_so[s2.leaf_sel][s2.leaf_bit] : s2.out_ok;
  assign in_pass  = s2.root ? s2_ti[s2.root_sel][s2.root_bit] : s2.in_ok;

  always_comb begin
    if (s2.same) begin
      reach_next = 1'b1;
    end else if (s2.below) begin
      reach_next = 1'b0;
    end else if (!s2.in_range) begin
      reach_next = 1'b0;
    end else if (s2.end_lt) begin
      reach_next = 1'b0;
    end else if (s2.start_le) begin
      reach_next = 1'b1;
    end else begin
      reach_next = out_pass && in_pass;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (adv) begin
      result.valid <= s2.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.reachable <= reach_next;
    end
  end

  // ---------------- assertions ---------------------------------------------
  a_query_enters: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready && (item.func == FUNC_QUERY) |=> s1_valid)
    else $error("accepted query did not reach stage 1");

  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready && (item.func != FUNC_QUERY) |=> !s1_valid)
    else $error("table write produced a pipeline slot");

  a_s1_to_s2: assert property (@(posedge clk) disable iff (rst)
    adv && (s1_valid != s2.valid) |=> (s2.valid == $past(s1_valid)))
    else $error("stage 1 valid lost on advance");

  a_same_true: assert property (@(posedge clk) disable iff (rst)
    adv && s2.valid && s2.same |=> result.valid && result.reachable)
    else $error("equal vertices must answer reachable");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(s2.valid) && $stable(s1_valid) && $stable(result.valid))
    else $error("pipeline moved during output stall");

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the Bloom-label reachability query block.
module tb_top import bfl_pkg::*; ();

  // Limit on consecutive cycles with no transaction on either channel. The longest
  // legitimate quiet stretch is the output hold-off of HOLD_OFF_CYCLES.
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_OFF_CYCLES = 300;
  // Allow a generous tail after the last result.
  localparam int TAIL_CYCLES = 12;
  localparam int POOL_SIZE = 16;

  localparam logic [VA_W-1:0] V_FIRST = '0;
  localparam logic [VA_W-1:0] V_LAST  = VA_W'(VERTEX_COUNT - 1);

  // One request as the sender sees it.
  typedef struct {
    func_t             func;
    logic [VA_W-1:0]   vertex;
    logic [VA_W-1:0]   target_vertex;
    logic [WSEL_W-1:0] word_index;
    logic [WORD_W-1:0] word_value;
    logic [MARK_W-1:0] interval_start;
    logic [MARK_W-1:0] interval_end;
    logic              no_in_edges;
    logic              no_out_edges;
  } vreq_t;

  logic clk;
  logic rst;

  bfl_item_if   item_ch ();
  bfl_result_if res_ch ();

  bfl_label_reachability_test u_top (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (res_ch)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the vertex table, updated at each accepted write transaction.
  // ---------------------------------------------------------------------------
  logic [MARK_W-1:0] entry_mark [VERTEX_COUNT];
  logic [MARK_W-1:0] exit_mark  [VERTEX_COUNT];
  bit                root_flag  [VERTEX_COUNT];
  bit                leaf_flag  [VERTEX_COUNT];
  label_row_t        out_rows   [VERTEX_COUNT];
  label_row_t        in_rows    [VERTEX_COUNT];

  // Answers still owed by the block, oldest first.
  bit reach_expected [$];

  // Vertices whose record and every label word have been written; only these
  // are ever named by a query, so no query reads an unwritten entry.
  logic [VA_W-1:0] pool [$];

  int tx_idle_pct;
  int rx_idle_pct;
  int rx_hold_cycles;

  int items_sent;
  int n_queries;
  int n_label_tests;
  int n_true;
  int n_results;
  int n_errors;

  // Bit idx of a label bitmap: word number wraps modulo the number of label words.
  function automatic bit label_bit(label_row_t row, logic [WORD_W-1:0] idx);
    int unsigned w;
    w = (idx >> 5) % LABEL_WORDS;
    return row[w][idx[4:0]];
  endfunction

  // Reachability answer from the shadow table, checks in priority order.
  function automatic bit predict_reach(logic [VA_W-1:0] src, logic [VA_W-1:0] dst);
    if (src == dst) return 1'b1;
    if (src < dst) return 1'b0;
    if (int'(src) >= VERTEX_COUNT || int'(dst) >= VERTEX_COUNT) return 1'b0;
    if (exit_mark[src] < exit_mark[dst]) return 1'b0;
    if (entry_mark[src] <= entry_mark[dst]) return 1'b1;
    n_label_tests++;
    // Outgoing: target labels must be covered by the source. A leaf target
    // keeps a single bit index in word 0 instead of a bitmap.
    if (leaf_flag[dst]) begin
      if (!label_bit(out_rows[src], out_rows[dst][0])) return 1'b0;
    end else begin
      for (int i = 0; i < LABEL_WORDS; i++)
        if ((out_rows[src][i] & out_rows[dst][i]) != out_rows[dst][i]) return 1'b0;
    end
    // Incoming: source labels must be covered by the target; a root source
    // keeps a bit index in its incoming word 0.
    if (root_flag[src]) begin
      if (!label_bit(in_rows[dst], in_rows[src][0])) return 1'b0;
    end else begin
      for (int i = 0; i < LABEL_WORDS; i++)
        if ((in_rows[src][i] & in_rows[dst][i]) != in_rows[src][i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Apply one accepted request to the shadow table or queue its answer.
  function automatic void track_request(vreq_t r);
    bit ans;
    case (r.func)
      FUNC_QUERY: begin
        ans = predict_reach(r.vertex, r.target_vertex);
        reach_expected.push_back(ans);
        n_queries++;
        if (ans) n_true++;
      end
      FUNC_REC: begin
        if (int'(r.vertex) < VERTEX_COUNT) begin
          entry_mark[r.vertex] = r.interval_start;
          exit_mark[r.vertex]  = r.interval_end;
          root_flag[r.vertex]  = r.no_in_edges;
          leaf_flag[r.vertex]  = r.no_out_edges;
        end
      end
      FUNC_OUT: begin
        if (int'(r.vertex) < VERTEX_COUNT && int'(r.word_index) < LABEL_WORDS)
          out_rows[r.vertex][r.word_index] = r.word_value;
      end
      default: begin
        if (int'(r.vertex) < VERTEX_COUNT && int'(r.word_index) < LABEL_WORDS)
          in_rows[r.vertex][r.word_index] = r.word_value;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Every field random; callers override what matters, so unused fields still
  // toggle on every transaction.
  function automatic vreq_t rand_req();
    vreq_t r;
    r.func           = func_t'($urandom_range(3));
    r.vertex         = VA_W'($urandom_range(VERTEX_COUNT - 1));
    r.target_vertex  = VA_W'($urandom_range(VERTEX_COUNT - 1));
    r.word_index     = WSEL_W'($urandom_range(LABEL_WORDS - 1));
    r.word_value     = $urandom;
    r.interval_start = MARK_W'($urandom_range(1024));
    r.interval_end   = MARK_W'($urandom_range(1024));
    r.no_in_edges    = 1'($urandom_range(1));
    r.no_out_edges   = 1'($urandom_range(1));
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return $urandom & $urandom;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [VA_W-1:0] pick_pool();
    return pool[$urandom_range(pool.size() - 1)];
  endfunction

  // Offer one request, with random idle cycles ahead of it, and hold it until the
  // transaction. Valid stays high on return so back-to-back items need no bubble.
  task automatic send_item(input vreq_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid          <= 1'b1;
    item_ch.func           <= r.func;
    item_ch.vertex         <= r.vertex;
    item_ch.target_vertex  <= r.target_vertex;
    item_ch.word_index     <= r.word_index;
    item_ch.word_value     <= r.word_value;
    item_ch.interval_start <= r.interval_start;
    item_ch.interval_end   <= r.interval_end;
    item_ch.no_in_edges    <= r.no_in_edges;
    item_ch.no_out_edges   <= r.no_out_edges;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    track_request(r);
    items_sent++;
  endtask

  // Drop valid when the sender goes quiet, so a held item is not taken twice.
  task automatic idle_bus();
    item_ch.valid <= 1'b0;
  endtask

  task automatic write_rec(input logic [VA_W-1:0] v, input logic [MARK_W-1:0] s,
                           input logic [MARK_W-1:0] e, input bit root, input bit leaf);
    vreq_t r;
    r = rand_req();
    r.func           = FUNC_REC;
    r.vertex         = v;
    r.interval_start = s;
    r.interval_end   = e;
    r.no_in_edges    = root;
    r.no_out_edges   = leaf;
    send_item(r);
  endtask

  task automatic write_label(input func_t f, input logic [VA_W-1:0] v,
                             input int unsigned w, input logic [WORD_W-1:0] val);
    vreq_t r;
    r = rand_req();
    r.func       = f;
    r.vertex     = v;
    r.word_index = WSEL_W'(w);
    r.word_value = val;
    send_item(r);
  endtask

  task automatic ask(input logic [VA_W-1:0] src, input logic [VA_W-1:0] dst);
    vreq_t r;
    r = rand_req();
    r.func          = FUNC_QUERY;
    r.vertex        = src;
    r.target_vertex = dst;
    send_item(r);
  endtask

  // One well-formed query setup: records steer the pair to a chosen decision
  // point, labels are built so the subset tests pass most of the time.
  task automatic run_scenario();
    logic [VA_W-1:0]   hi, lo, tmp;
    int unsigned       kind, sd, ed, ss, es, w;
    bit                leaf_d, root_s;
    logic [WORD_W-1:0] b, m;
    hi = pick_pool();
    lo = pick_pool();
    if (hi == lo) begin
      ask(hi, lo);
      return;
    end
    if (hi < lo) begin
      tmp = hi;
      hi  = lo;
      lo  = tmp;
    end
    kind   = $urandom_range(9);
    leaf_d = 1'($urandom_range(1));
    root_s = 1'($urandom_range(1));
    sd     = $urandom_range(1023);
    ed     = $urandom_range(1024);
    case (kind)
      0: begin
        // source exits before the target: rejected on exit markers
        ed = $urandom_range(1024, 1);
        es = $urandom_range(ed - 1, 0);
        ss = $urandom_range(1024);
      end
      1: begin
        // interval containment answers directly
        es = $urandom_range(1024, ed);
        ss = $urandom_range(sd, 0);
      end
      default: begin
        // falls through to the label tests
        es = $urandom_range(1024, ed);
        ss = $urandom_range(1024, sd + 1);
      end
    endcase
    write_rec(lo, MARK_W'(sd), MARK_W'(ed), 1'($urandom_range(1)), leaf_d);
    write_rec(hi, MARK_W'(ss), MARK_W'(es), root_s, 1'($urandom_range(1)));
    if (kind >= 2) begin
      if (leaf_d) begin
        // leaf target: point its index at a bit of the source, usually set
        b = $urandom;
        w = (b >> 5) % LABEL_WORDS;
        write_label(FUNC_OUT, lo, 0, b);
        m = out_rows[hi][w];
        m[b[4:0]] = ($urandom_range(3) != 0);
        write_label(FUNC_OUT, hi, w, m);
      end else if ($urandom_range(2) != 0) begin
        for (int i = 0; i < LABEL_WORDS; i++) begin
          m = out_rows[hi][i] & $urandom;
          if ($urandom_range(15) == 0) m[$urandom_range(31)] = 1'b1;
          write_label(FUNC_OUT, lo, i, m);
        end
      end
      if (root_s) begin
        // root source: its index selects a bit of the target's incoming label
        b = $urandom;
        w = (b >> 5) % LABEL_WORDS;
        write_label(FUNC_IN, hi, 0, b);
        m = in_rows[lo][w];
        m[b[4:0]] = ($urandom_range(3) != 0);
        write_label(FUNC_IN, lo, w, m);
      end else if ($urandom_range(2) != 0) begin
        for (int i = 0; i < LABEL_WORDS; i++) begin
          m = in_rows[lo][i] & $urandom;
          if ($urandom_range(15) == 0) m[$urandom_range(31)] = 1'b1;
          write_label(FUNC_IN, hi, i, m);
        end
      end
    end
    ask(hi, lo);
    if ($urandom_range(3) == 0) ask(lo, hi);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Fill the record and all label words of a set of vertices, corners included.
  task automatic test_preload_pool();
    logic [VA_W-1:0] v;
    bit              taken [VERTEX_COUNT];
    pool.push_back(V_FIRST);
    pool.push_back(V_LAST);
    taken[V_FIRST] = 1'b1;
    taken[V_LAST] = 1'b1;
    while (pool.size() < POOL_SIZE) begin
      v = VA_W'($urandom_range(VERTEX_COUNT - 1));
      if (!taken[v]) begin
        taken[v] = 1'b1;
        pool.push_back(v);
      end
    end
    foreach (pool[k]) begin
      write_rec(pool[k], MARK_W'($urandom_range(1024)), MARK_W'($urandom_range(1024)),
                1'($urandom_range(1)), 1'($urandom_range(1)));
      for (int i = 0; i < LABEL_WORDS; i++) begin
        write_label(FUNC_OUT, pool[k], i, rand_word());
        write_label(FUNC_IN, pool[k], i, rand_word());
      end
    end
  endtask

  // Equality, index order, exit markers, entry markers; marker extremes.
  task automatic test_order_rules();
    ask(V_LAST, V_LAST);
    ask(V_FIRST, V_LAST);
    write_rec(V_LAST, 11'd5, 11'd0, 1'b0, 1'b0);
    write_rec(V_FIRST, 11'd0, 11'd1024, 1'b0, 1'b0);
    ask(V_LAST, V_FIRST);
    write_rec(V_LAST, 11'd0, 11'd1024, 1'b0, 1'b0);
    write_rec(V_FIRST, 11'd1024, 11'd1024, 1'b0, 1'b0);
    ask(V_LAST, V_FIRST);
  endtask

  // Leaf target and root source with single-bit labels; the all-ones index
  // also exercises the wrap of the word number.
  task automatic test_label_index_rules();
    write_rec(V_LAST, 11'd1024, 11'd1024, 1'b1, 1'b0);
    write_rec(V_FIRST, 11'd0, 11'd0, 1'b0, 1'b1);
    write_label(FUNC_OUT, V_FIRST, 0, 32'hFFFF_FFFF);
    write_label(FUNC_OUT, V_LAST, 7, 32'h8000_0000);
    write_label(FUNC_IN, V_LAST, 0, 32'h0000_0025);
    write_label(FUNC_IN, V_FIRST, 1, 32'h0000_0020);
    ask(V_LAST, V_FIRST);
    write_label(FUNC_OUT, V_LAST, 7, 32'h7FFF_FFFF);
    ask(V_LAST, V_FIRST);
    write_label(FUNC_OUT, V_LAST, 7, 32'hFFFF_FFFF);
    write_label(FUNC_IN, V_FIRST, 1, 32'h0000_0000);
    ask(V_LAST, V_FIRST);
  endtask

  // Mostly structured scenarios, a quarter loose random items.
  task automatic test_random_traffic(input int n);
    int    stop_at;
    vreq_t r;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      if ($urandom_range(3) == 0) begin
        r = rand_req();
        if (r.func == FUNC_QUERY) begin
          r.vertex        = pick_pool();
          r.target_vertex = pick_pool();
        end
        send_item(r);
      end else begin
        run_scenario();
      end
    end
  endtask

  // Receiver stops for a long stretch while queries keep coming: the pipeline
  // fills and the input must back up without losing anything.
  task automatic test_output_hold_off();
    rx_hold_cycles = HOLD_OFF_CYCLES;
    repeat (40) ask(pick_pool(), pick_pool());
  endtask

  // Sender stops until the block has drained every answer, then resumes.
  task automatic test_drain_pause();
    repeat (6) run_scenario();
    idle_bus();
    while (reach_expected.size() != 0) @(posedge clk);
    repeat (6) run_scenario();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random ready, or a counted hold-off when one is requested.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_cycles > 0) begin
        res_ch.ready <= 1'b0;
        rx_hold_cycles--;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Each result transaction is matched against the oldest pending answer.
  always @(posedge clk) begin : result_check
    bit want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      n_results++;
      if (reach_expected.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result: expected none, actual reachable=%b",
                 $time, res_ch.reachable);
      end else begin
        want = reach_expected.pop_front();
        if (res_ch.reachable !== want) begin
          n_errors++;
          $display("%0t: reachable mismatch: expected %b, actual %b",
                   $time, want, res_ch.reachable);
        end
      end
    end
  end

  // Watchdog: too long without any transaction means the block hung.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("tb_top failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    tx_idle_pct    = 11;
    rx_idle_pct    = 51;
    rx_hold_cycles = 0;
    items_sent     = 0;
    n_queries      = 0;
    n_label_tests  = 0;
    n_true         = 0;
    n_results      = 0;
    n_errors       = 0;

    rst                    <= 1'b1;
    item_ch.valid          <= 1'b0;
    item_ch.func           <= FUNC_REC;
    item_ch.vertex         <= '0;
    item_ch.target_vertex  <= '0;
    item_ch.word_index     <= '0;
    item_ch.word_value     <= '0;
    item_ch.interval_start <= '0;
    item_ch.interval_end   <= '0;
    item_ch.no_in_edges    <= 1'b0;
    item_ch.no_out_edges   <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Phase 1: sender mostly busy, receiver stalls half the time.
    test_preload_pool();
    test_order_rules();
    test_label_index_rules();
    test_random_traffic(300);

    // Phase 2: roles swapped.
    tx_idle_pct = 51;
    rx_idle_pct = 11;
    test_random_traffic(300);

    // Phase 3: full rate, with a long output stall and a drain pause.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_output_hold_off();
    test_drain_pause();
    test_random_traffic(250);

    idle_bus();
    while (reach_expected.size() != 0) @(posedge clk);
    // extra cycles catch any stray result after the last expected one
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d transactions, %0d queries (%0d answered true, %0d via label tests).",
             items_sent, n_queries, n_true, n_label_tests);
    $display("Checked %0d results across three idle mixes, a long hold-off and a drain.",
             n_results);
    if (n_errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
